/* hw/rtl/gmem_pkg.sv */
// Package for the max-elevation grid map: widths, codes, state types.
// No dependencies.
package gmem_pkg;
   localparam int MaxColsDefault = 256;
   localparam int MaxRowsDefault = 256;
   localparam int CoordW = 24;

   localparam logic [1:0] ModeSingle = 2'd0;
   localparam logic [1:0] ModeBatch  = 2'd1;
   localparam logic [1:0] ModeQuery  = 2'd2;

   localparam logic [1:0] StatDone = 2'd0;
   localparam logic [1:0] StatSkip = 2'd1;
   localparam logic [1:0] StatErr  = 2'd2;

   localparam logic [2:0] RegXStart = 3'd0;
   localparam logic [2:0] RegXEnd   = 3'd1;
   localparam logic [2:0] RegZStart = 3'd2;
   localparam logic [2:0] RegZEnd   = 3'd3;
   localparam logic [2:0] RegCols   = 3'd4;
   localparam logic [2:0] RegRows   = 3'd5;
   localparam logic [2:0] RegLimit  = 3'd6;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DIVX, ST_DIVZ, ST_ADDR, ST_READ, ST_UPDATE, ST_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [23:0] point_x;
      logic [23:0] point_z;
      logic [23:0] point_height;
      logic [7:0]  query_col;
      logic [7:0]  query_row;
      logic [23:0] plane_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [23:0] cell_height;
      logic        cell_seen;
      logic [23:0] center_x;
      logic [24:0] center_y;
      logic [23:0] center_z;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic done;
   } div_ctl_type;
endpackage

/* hw/rtl/gmem_if.sv */
// Valid/ready channel carrying one word of payload type.
// Depends on gmem_pkg for payload types.
interface gmem_req_if;
   logic valid;
   logic ready;
   gmem_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface gmem_rsp_if;
   logic valid;
   logic ready;
   gmem_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/gmem_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on gmem_pkg.
module gmem_div #(
   parameter int NW = 34,
   parameter int DW = 25
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [NW-1:0]      num,
   input  logic [DW-1:0]      den,
   output gmem_pkg::div_ctl_type ctl,
   output logic [NW-1:0]      quo
);
   localparam int CW = $clog2(NW + 1);
   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   r_ff, r_in;
   logic [DW-1:0] d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [DW:0]   trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff[DW-1:0], q_ff[NW-1]};
      if (start) begin
         q_in = num; r_in = '0; d_in = den; cnt_in = CW'(NW); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign ctl.start = start;
   assign ctl.done  = done_ff;
   assign quo = q_ff;
endmodule

/* hw/rtl/grid_max_elevation_map_top.sv */
// Top level of the max-elevation grid map: CSR port, sequencer, cell store.
// Depends on gmem_pkg, gmem_if and gmem_div.
//
// Usage: point and query words enter on req (valid/ready); one result word
// per request leaves on rsp. Users must write registers (csr_ APB port, byte
// address 4*i) only while no word is in flight; the block does not check.
// Sequence: each request runs two divisions on the one shared divider (x then
// z), each with a launch, 34 quotient bits and a capture. Address, store
// read, update and result load follow, then rsp_valid rises. Queries use
// the same divider for the cell centers. Out-of-range or unused-mode words
// still run the whole sequence.
// Flow: only one word is in flight; req_ready is low while working.
// Reset: registers take their reset values, then a clearing pass writes all
// MAX_COLS*MAX_ROWS store entries to zero, one a cycle, with req_ready low.
// CSR writes are taken during the pass.
// Stall: the result is held in rsp until taken; the next request is accepted
// in the same cycle the result leaves or after.
module grid_max_elevation_map_top #(
   parameter int MAX_COLS = gmem_pkg::MaxColsDefault,
   parameter int MAX_ROWS = gmem_pkg::MaxRowsDefault
) (
   input  logic        clock,
   input  logic        reset,
   gmem_req_if.sink    req,
   gmem_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = 34;   // 24-bit span times up to 10-bit factor
   localparam int DW = 25;

   // registers
   logic signed [23:0] xs_ff, xe_ff, zs_ff, ze_ff, lim_ff;
   logic [8:0] ncol_reg_ff, nrow_reg_ff;
   logic wr_en;
   logic [2:0] reg_idx;
   assign csr_pready = 1'b1;
   assign reg_idx = csr_paddr[4:2];
   assign wr_en = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         xs_ff <= '0; xe_ff <= 24'sd2560; zs_ff <= '0; ze_ff <= 24'sd2560;
         ncol_reg_ff <= 9'd100; nrow_reg_ff <= 9'd100; lim_ff <= 24'sd256;
      end else if (wr_en) begin
         case (reg_idx)
            gmem_pkg::RegXStart: xs_ff <= csr_pwdata[23:0];
            gmem_pkg::RegXEnd:   xe_ff <= csr_pwdata[23:0];
            gmem_pkg::RegZStart: zs_ff <= csr_pwdata[23:0];
            gmem_pkg::RegZEnd:   ze_ff <= csr_pwdata[23:0];
            gmem_pkg::RegCols:   ncol_reg_ff <= csr_pwdata[8:0];
            gmem_pkg::RegRows:   nrow_reg_ff <= csr_pwdata[8:0];
            gmem_pkg::RegLimit:  lim_ff <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         gmem_pkg::RegXStart: csr_prdata = {{8{xs_ff[23]}}, xs_ff};
         gmem_pkg::RegXEnd:   csr_prdata = {{8{xe_ff[23]}}, xe_ff};
         gmem_pkg::RegZStart: csr_prdata = {{8{zs_ff[23]}}, zs_ff};
         gmem_pkg::RegZEnd:   csr_prdata = {{8{ze_ff[23]}}, ze_ff};
         gmem_pkg::RegCols:   csr_prdata = {23'd0, ncol_reg_ff};
         gmem_pkg::RegRows:   csr_prdata = {23'd0, nrow_reg_ff};
         gmem_pkg::RegLimit:  csr_prdata = {{8{lim_ff[23]}}, lim_ff};
         default:             csr_prdata = '0;
      endcase
   end

   // effective cell counts: zero reads as one, saturate at the parameter;
   // the 9-bit registers keep them below 512
   logic [8:0] ncol, nrow;
   always_comb begin
      if (ncol_reg_ff == 9'd0) ncol = 9'd1;
      else if (32'(ncol_reg_ff) > MAX_COLS) ncol = 9'(MAX_COLS);
      else ncol = ncol_reg_ff;
      if (nrow_reg_ff == 9'd0) nrow = 9'd1;
      else if (32'(nrow_reg_ff) > MAX_ROWS) nrow = 9'(MAX_ROWS);
      else nrow = nrow_reg_ff;
   end

   // sequencer
   gmem_pkg::state_type st_ff, st_in;
   gmem_pkg::req_type   r_ff;
   gmem_pkg::rsp_type   o_ff, o_in;
   logic [8:0] col_ff, row_ff;
   logic signed [23:0] cx_ff, cz_ff;
   logic [AW-1:0] clr_ff, idx_ff;
   logic ov_ff, launch_ff;
   logic do_start, acc, on_x;
   logic [NW-1:0] num_s, quo, q_lim;
   logic [DW-1:0] den_s;
   gmem_pkg::div_ctl_type dctl;

   gmem_div #(.NW(NW), .DW(DW)) u_div (
      .clock(clock), .reset(reset), .start(do_start), .num(num_s), .den(den_s),
      .ctl(dctl), .quo(quo)
   );

   // per-axis operands
   logic signed [24:0] spx, spz, offx, offz;
   logic okx, okz, isq;
   assign isq  = (r_ff.mode == gmem_pkg::ModeQuery);
   assign spx  = 25'(xe_ff) - 25'(xs_ff);
   assign spz  = 25'(ze_ff) - 25'(zs_ff);
   assign offx = 25'(signed'(r_ff.point_x)) - 25'(xs_ff);
   assign offz = 25'(signed'(r_ff.point_z)) - 25'(zs_ff);
   assign okx = (spx > 0) && (offx >= 0) && (offx <= spx);
   assign okz = (spz > 0) && (offz >= 0) && (offz <= spz);

   // next state and handshake
   always_comb begin
      st_in = st_ff;
      req.ready = 1'b0;
      do_start = 1'b0;
      case (st_ff)
         gmem_pkg::ST_CLEAR: begin
            if (clr_ff == AW'(DEPTH - 1)) st_in = gmem_pkg::ST_IDLE;
         end
         gmem_pkg::ST_IDLE: begin
            req.ready = !ov_ff || rsp.ready;
            if (req.valid && (!ov_ff || rsp.ready)) st_in = gmem_pkg::ST_DIVX;
         end
         gmem_pkg::ST_DIVX, gmem_pkg::ST_DIVZ: begin
            do_start = !launch_ff;
            if (launch_ff && dctl.done)
               st_in = on_x ? gmem_pkg::ST_DIVZ : gmem_pkg::ST_ADDR;
         end
         gmem_pkg::ST_ADDR:   st_in = gmem_pkg::ST_READ;
         gmem_pkg::ST_READ:   st_in = gmem_pkg::ST_UPDATE;
         gmem_pkg::ST_UPDATE: st_in = gmem_pkg::ST_OUT;
         gmem_pkg::ST_OUT:    st_in = gmem_pkg::ST_IDLE;
         default:             st_in = gmem_pkg::ST_IDLE;
      endcase
   end

   assign acc  = (st_ff == gmem_pkg::ST_IDLE) && req.valid && req.ready;
   assign on_x = (st_ff == gmem_pkg::ST_DIVX);

   // divider operands: bin index off*n/span, or center offset (2c+1)*span/(2n)
   logic signed [24:0] sp_a, off_a;
   logic [8:0] n_a, cell_a;
   always_comb begin
      sp_a   = on_x ? spx : spz;
      off_a  = on_x ? offx : offz;
      n_a    = on_x ? ncol : nrow;
      cell_a = on_x ? 9'(r_ff.query_col) : 9'(r_ff.query_row);
      if (isq) begin
         num_s = NW'({cell_a, 1'b1}) * NW'(sp_a[23:0]);
         den_s = DW'({n_a, 1'b0});
      end else begin
         num_s = NW'(off_a[23:0]) * NW'(n_a);
         den_s = DW'(sp_a[23:0]);
      end
      q_lim = quo;
      // point on the upper edge lands in the last cell
      if (!isq && quo >= NW'(n_a)) q_lim = NW'(n_a) - 1'b1;
   end

   logic qbad;
   assign qbad = (9'(r_ff.query_col) >= ncol) || (9'(r_ff.query_row) >= nrow);

   always_ff @(posedge clock) begin
      if (acc) r_ff <= req.data;
      if (reset) begin
         st_ff <= gmem_pkg::ST_CLEAR; clr_ff <= '0; launch_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (st_ff == gmem_pkg::ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (do_start) launch_ff <= 1'b1;
         else if (launch_ff && dctl.done) launch_ff <= 1'b0;
         if (st_ff == gmem_pkg::ST_OUT) ov_ff <= 1'b1;
         else if (rsp.valid && rsp.ready) ov_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (launch_ff && dctl.done) begin
         if (on_x) begin
            col_ff <= 9'(q_lim);
            cx_ff <= (spx > 0) ? 24'(25'(xs_ff) + 25'(quo)) : xs_ff;
         end else begin
            row_ff <= 9'(q_lim);
            cz_ff <= (spz > 0) ? 24'(25'(zs_ff) + 25'(quo)) : zs_ff;
         end
      end
      if (st_ff == gmem_pkg::ST_ADDR) begin
         if (isq)
            idx_ff <= AW'(32'(r_ff.query_row) * 32'(ncol) + 32'(r_ff.query_col));
         else
            idx_ff <= AW'(32'(row_ff) * 32'(ncol) + 32'(col_ff));
      end
   end

   // store access and result build
   logic signed [23:0] hmem [DEPTH];
   logic               smem [DEPTH];
   logic signed [23:0] hrd_ff;
   logic               srd_ff;
   logic upd_ok, skip;
   assign skip = (r_ff.mode == gmem_pkg::ModeBatch) &&
                 (signed'(r_ff.point_height) > lim_ff);
   assign upd_ok = (r_ff.mode == gmem_pkg::ModeSingle || r_ff.mode == gmem_pkg::ModeBatch)
                   && okx && okz && !skip;

   logic st_we;
   logic [AW-1:0] st_wa;
   logic signed [23:0] st_wh;
   logic st_ws;
   always_comb begin
      st_we = 1'b0; st_wa = clr_ff; st_wh = '0; st_ws = 1'b0;
      if (st_ff == gmem_pkg::ST_CLEAR) st_we = 1'b1;
      else if (st_ff == gmem_pkg::ST_UPDATE && upd_ok) begin
         st_we = 1'b1; st_wa = idx_ff; st_ws = 1'b1;
         st_wh = (hrd_ff < signed'(r_ff.point_height)) ? r_ff.point_height : hrd_ff;
      end
   end

   // one write port, one registered read at idx_ff
   always_ff @(posedge clock) begin
      if (st_we) begin
         hmem[st_wa] <= st_wh;
         smem[st_wa] <= st_ws;
      end
      hrd_ff <= hmem[idx_ff];
      srd_ff <= smem[idx_ff];
   end

   always_comb begin
      o_in = '0;
      case (r_ff.mode)
         gmem_pkg::ModeSingle, gmem_pkg::ModeBatch: begin
            if (!(okx && okz))
               o_in.status = (r_ff.mode == gmem_pkg::ModeSingle) ?
                             gmem_pkg::StatErr : gmem_pkg::StatSkip;
            else if (skip) o_in.status = gmem_pkg::StatSkip;
            else o_in.status = gmem_pkg::StatDone;
         end
         gmem_pkg::ModeQuery: begin
            if (qbad) o_in.status = gmem_pkg::StatErr;
            else begin
               o_in.status = gmem_pkg::StatDone;
               o_in.cell_height = hrd_ff;
               o_in.cell_seen = srd_ff;
               o_in.center_x = cx_ff;
               o_in.center_z = cz_ff;
               o_in.center_y = 25'(hrd_ff) - 25'(signed'(r_ff.plane_offset));
            end
         end
         default: o_in.status = gmem_pkg::StatDone;
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_ff == gmem_pkg::ST_UPDATE) o_ff <= o_in;
   end

   assign rsp.valid = ov_ff;
   assign rsp.data  = o_ff;
endmodule

/* tb/testbench.sv */
// Self-checking testbench for grid_max_elevation_map_top: point and query words
// against a built-in cell-store predictor and an in-order scoreboard.
// Depends on gmem_pkg, gmem_if and the block's RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NCOLS = 256;
   localparam int NROWS = 256;

   // Scoreboard: holds predicted result words in order, compares arrivals.
   class result_board;
      gmem_pkg::rsp_type pending[$];
      int mismatches;
      int strays;

      function void note(gmem_pkg::rsp_type r);
         pending.push_back(r);
      endfunction

      function void check(gmem_pkg::rsp_type got);
         gmem_pkg::rsp_type want;
         if (pending.size() == 0) begin
            strays++;
            if (mismatches + strays <= 10)
               $display("unexpected result word %h", got);
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status || got.cell_height !== want.cell_height ||
             got.cell_seen !== want.cell_seen || got.center_x !== want.center_x ||
             got.center_y !== want.center_y || got.center_z !== want.center_z) begin
            mismatches++;
            if (mismatches + strays <= 10)
               $display({"mismatch: exp st=%0d h=%h s=%b cx=%h cy=%h cz=%h",
                         " / got st=%0d h=%h s=%b cx=%h cy=%h cz=%h"},
                  want.status, want.cell_height, want.cell_seen, want.center_x,
                  want.center_y, want.center_z, got.status, got.cell_height,
                  got.cell_seen, got.center_x, got.center_y, got.center_z);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   gmem_req_if req_ch();
   gmem_rsp_if rsp_ch();

   grid_max_elevation_map_top u_top (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #4 clock = ~clock;

   // Predictor copy of registers and cell stores.
   logic signed [23:0] x_lo, x_hi, z_lo, z_hi, h_limit;
   logic [8:0] n_across, n_along;
   logic signed [23:0] elev_mem [NCOLS*NROWS];
   bit seen_mem [NCOLS*NROWS];

   result_board board = new();
   bit quiet;          // true: no random idling on either side

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
   end

   function automatic int unsigned used_cells(logic [8:0] r, int unsigned lim);
      if (r == 0) return 1;
      return (r > lim) ? lim : r;
   endfunction

   // Bin a coordinate; returns -1 when out of range.
   function automatic longint bin_index(longint v, longint lo, longint hi,
                                        int unsigned cells);
      longint q;
      if (hi <= lo || v < lo || v > hi) return -1;
      q = ((v - lo) * cells) / (hi - lo);
      if (q >= cells) q = cells - 1;
      return q;
   endfunction

   function automatic longint cell_center(longint lo, longint hi, int unsigned c,
                                          int unsigned cells);
      if (hi <= lo) return lo;
      return lo + ((2 * longint'(c) + 1) * (hi - lo)) / (2 * longint'(cells));
   endfunction

   function automatic gmem_pkg::rsp_type predict_cell(gmem_pkg::req_type w);
      gmem_pkg::rsp_type r;
      int unsigned nc, nr, idx;
      longint col, row, hv;
      r = '0;
      nc = used_cells(n_across, NCOLS);
      nr = used_cells(n_along, NROWS);
      if (w.mode == gmem_pkg::ModeSingle || w.mode == gmem_pkg::ModeBatch) begin
         col = bin_index(longint'($signed(w.point_x)), x_lo, x_hi, nc);
         row = bin_index(longint'($signed(w.point_z)), z_lo, z_hi, nr);
         if (col < 0 || row < 0) begin
            r.status = (w.mode == gmem_pkg::ModeSingle) ? gmem_pkg::StatErr
                                                        : gmem_pkg::StatSkip;
         end else if (w.mode == gmem_pkg::ModeBatch &&
                      $signed(w.point_height) > h_limit) begin
            r.status = gmem_pkg::StatSkip;
         end else begin
            idx = 32'(row * nc + col);
            if (elev_mem[idx] < $signed(w.point_height)) elev_mem[idx] = w.point_height;
            seen_mem[idx] = 1'b1;
            r.status = gmem_pkg::StatDone;
         end
      end else if (w.mode == gmem_pkg::ModeQuery) begin
         if (w.query_col >= nc || w.query_row >= nr) begin
            r.status = gmem_pkg::StatErr;
         end else begin
            idx = 32'(w.query_row) * nc + 32'(w.query_col);
            hv = elev_mem[idx];
            r.status = gmem_pkg::StatDone;
            r.cell_height = hv[23:0];
            r.cell_seen = seen_mem[idx];
            r.center_x = 24'(cell_center(x_lo, x_hi, w.query_col, nc));
            r.center_y = 25'(hv - longint'($signed(w.plane_offset)));
            r.center_z = 24'(cell_center(z_lo, z_hi, w.query_row, nr));
         end
      end else begin
         r.status = gmem_pkg::StatDone;
      end
      return r;
   endfunction

   // APB write: setup then access cycle; predictor updated alongside.
   task automatic csr_write(logic [2:0] reg_id, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {reg_id, 2'b00}; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (reg_id)
         gmem_pkg::RegXStart: x_lo = value[23:0];
         gmem_pkg::RegXEnd:   x_hi = value[23:0];
         gmem_pkg::RegZStart: z_lo = value[23:0];
         gmem_pkg::RegZEnd:   z_hi = value[23:0];
         gmem_pkg::RegCols:   n_across = value[8:0];
         gmem_pkg::RegRows:   n_along = value[8:0];
         gmem_pkg::RegLimit:  h_limit = value[23:0];
         default: ;
      endcase
   endtask

   task automatic set_grid(int xs, int xe, int zs, int ze, int nc, int nr, int lim);
      csr_write(gmem_pkg::RegXStart, 32'(xs));
      csr_write(gmem_pkg::RegXEnd, 32'(xe));
      csr_write(gmem_pkg::RegZStart, 32'(zs));
      csr_write(gmem_pkg::RegZEnd, 32'(ze));
      csr_write(gmem_pkg::RegCols, 32'(nc));
      csr_write(gmem_pkg::RegRows, 32'(nr));
      csr_write(gmem_pkg::RegLimit, 32'(lim));
   endtask

   // Offer one word; predict at acceptance. valid stays up after acceptance
   // until the next word or an idle cycle replaces it.
   task automatic send_word(gmem_pkg::req_type w);
      while (!quiet && $urandom_range(99) < 16) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= w;
      do @(posedge clock); while (!req_ch.ready);
      board.note(predict_cell(w));
   endtask

   // Wait until all results back, then let the sequencer settle.
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic gmem_pkg::req_type point_word(logic [1:0] m, int x, int z, int h);
      gmem_pkg::req_type w;
      w = '0;
      w.mode = m; w.point_x = 24'(x); w.point_z = 24'(z); w.point_height = 24'(h);
      w.query_col = 8'($urandom); w.query_row = 8'($urandom);
      w.plane_offset = 24'($urandom);
      return w;
   endfunction

   function automatic gmem_pkg::req_type query_word(int c, int r, int po);
      gmem_pkg::req_type w;
      w = '0;
      w.mode = gmem_pkg::ModeQuery; w.query_col = 8'(c); w.query_row = 8'(r);
      w.plane_offset = 24'(po);
      w.point_x = 24'($urandom); w.point_z = 24'($urandom);
      w.point_height = 24'($urandom);
      return w;
   endfunction

   // Random word biased into the current grid.
   function automatic gmem_pkg::req_type random_word();
      gmem_pkg::req_type w;
      longint xs, zs;
      int unsigned k;
      k = $urandom_range(99);
      xs = longint'(x_hi) - longint'(x_lo);
      zs = longint'(z_hi) - longint'(z_lo);
      if (k < 10) begin
         w.mode = 2'($urandom);
         w.point_x = 24'($urandom); w.point_z = 24'($urandom);
         w.point_height = 24'($urandom);
         w.query_col = 8'($urandom); w.query_row = 8'($urandom);
         w.plane_offset = 24'($urandom);
      end else if (k < 55) begin
         w = point_word(2'($urandom_range(1)), 0, 0,
                        ($urandom_range(1) != 0) ? int'($urandom)
                                                 : int'($urandom_range(600)) - 300);
         w.point_x = (xs > 0) ? 24'(longint'(x_lo) + longint'($urandom) % (xs + 1))
                              : 24'($urandom);
         w.point_z = (zs > 0) ? 24'(longint'(z_lo) + longint'($urandom) % (zs + 1))
                              : 24'($urandom);
      end else begin
         w = query_word(int'($urandom_range(used_cells(n_across, NCOLS))),
                        int'($urandom_range(used_cells(n_along, NROWS))),
                        int'($urandom));
      end
      return w;
   endfunction

   // Result side: random stalls except in quiet stretches.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) board.check(rsp_ch.data);
         rsp_ch.ready <= quiet || ($urandom_range(99) >= 16);
      end
   end

   initial begin
      x_lo = 0; x_hi = 2560; z_lo = 0; z_hi = 2560;
      n_across = 100; n_along = 100; h_limit = 256;
      foreach (elev_mem[i]) begin
         elev_mem[i] = '0;
         seen_mem[i] = 1'b0;
      end
      quiet = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset grid, edges, limits, bad modes.
      send_word(query_word(0, 0, 0));
      send_word(point_word(gmem_pkg::ModeSingle, 0, 0, 8388607));
      send_word(point_word(gmem_pkg::ModeSingle, 2560, 2560, 5));  // upper edge clamps
      send_word(point_word(gmem_pkg::ModeSingle, 2561, 0, 5));     // beyond end
      send_word(point_word(gmem_pkg::ModeSingle, -1, 0, 5));       // below start
      send_word(point_word(gmem_pkg::ModeBatch, 100, 100, 257));   // above limit
      send_word(point_word(gmem_pkg::ModeBatch, 100, 100, 256));
      send_word(point_word(gmem_pkg::ModeBatch, 3000, 100, 0));    // out of range, skip
      send_word(point_word(gmem_pkg::ModeSingle, 100, 100, -8388608));
      send_word(point_word(2'd3, 10, 10, 10));                     // unused mode
      send_word(query_word(0, 0, -8388608));
      send_word(query_word(99, 99, 8388607));
      send_word(query_word(3, 3, 0));
      send_word(query_word(100, 0, 0));                            // column past grid
      send_word(query_word(0, 255, 0));
      wait_idle();

      // Largest grid, extreme edges, max cell counts.
      set_grid(-8388608, 8388607, -8388608, 8388607, 256, 256, 8388607);
      send_word(point_word(gmem_pkg::ModeSingle, -8388608, -8388608, 1));
      send_word(point_word(gmem_pkg::ModeSingle, 8388607, 8388607, 2));
      send_word(query_word(255, 255, 0));
      send_word(query_word(0, 0, 8388607));
      wait_idle();

      // Zero cell counts, saturated counts, empty spans.
      set_grid(500, 500, 0, -10, 0, 511, -8388608);
      send_word(point_word(gmem_pkg::ModeSingle, 500, 0, 1));
      send_word(query_word(0, 5, 3));
      send_word(query_word(1, 0, 3));
      wait_idle();

      // Random phases over several settings; pausing for drain between them.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: set_grid(0, 2560, 0, 2560, 8, 8, 256);
            1: set_grid(-1000, 3000, -500, 500, 256, 3, 100);
            2: set_grid(int'($urandom_range(1000)), 4000 + int'($urandom_range(9000)),
                        -int'($urandom_range(1000)), int'($urandom_range(9000)) + 1,
                        int'($urandom_range(1, 20)), int'($urandom_range(1, 20)),
                        int'($urandom_range(400)) - 200);
            default: set_grid(0, 2560, 0, 2560, 16, 16, 8388607);
         endcase
         quiet = (ph == 3);      // long stretch with no idling
         for (int i = 0; i < 100; i++) send_word(random_word());
         quiet = 1'b0;
         wait_idle();
      end
      if (board.mismatches == 0 && board.strays == 0 && board.pending.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog: clear pass plus ~420 words and stalls.
   initial begin
      #(8ns * 2000000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

/* grid_max_elevation_map_top.f */
hw/rtl/gmem_pkg.sv
hw/rtl/gmem_if.sv
hw/rtl/gmem_div.sv
hw/rtl/grid_max_elevation_map_top.sv
tb/testbench.sv
